FILE: rtl/core/tlpt_pkg.sv
// tlpt_pkg: shared widths, request codes and status codes of the two-level page table unit
// no dependencies; used by tlpt_table_ram and two_level_page_table_unit
package tlpt_pkg;

    localparam int OP_W       = 2;
    localparam int ADDR_W     = 32;
    localparam int FLAGS_W    = 12;
    localparam int OFFS_W     = 12;
    localparam int DIR_IDX_W  = 10;
    localparam int TBL_IDX_W  = 10;
    localparam int ENTRY_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 40;

    localparam int DIR_DEPTH  = 1 << DIR_IDX_W;

    // request codes
    localparam logic [OP_W-1:0] OP_MAP    = 2'd0;
    localparam logic [OP_W-1:0] OP_UNMAP  = 2'd1;
    localparam logic [OP_W-1:0] OP_XLATE  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOTABLE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOSLOT  = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic                hit;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

FILE: rtl/core/tlpt_table_ram.sv
// tlpt_table_ram: single-port store of second-level page table entries
// depends on tlpt_pkg for the entry width
module tlpt_table_ram #(
    parameter int DEPTH  = 16384,
    parameter int AW     = 14
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                addr,
    input  logic [tlpt_pkg::ENTRY_W-1:0] wdata,
    output logic [tlpt_pkg::ENTRY_W-1:0] rdata
);

    logic [tlpt_pkg::ENTRY_W-1:0] mem [0:DEPTH-1];
    logic [tlpt_pkg::ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/two_level_page_table_unit.sv
// two_level_page_table_unit: map, unmap and translate over a two-level page table;
// the directory is read first, then a translate reads the table entry, and a map that
// allocates a table sweeps its 1024 entries, one per cycle, writing the mapped entry in passing
// one request at a time: s_axis_tready stays low until the result has gone into the output register
// reset: async active low; then a directory clearing pass over all 1024 entries with s_axis_tready low
// depends on tlpt_pkg and tlpt_table_ram
module two_level_page_table_unit #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: virtual_address[31:0], physical_address[63:32], page_flags[75:64], zero pad
    input  logic [tlpt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: operation[1:0]
    input  logic [tlpt_pkg::OP_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: translated_address[31:0], hit[32], status[34:33], zero pad
    output logic [tlpt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // slot number width, and a count that can hold TABLE_SLOTS itself
    localparam int SLOT_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W    = $clog2(TABLE_SLOTS + 1);
    localparam int DIR_W    = SLOT_W + 1;
    localparam int TDEPTH   = TABLE_SLOTS * (1 << tlpt_pkg::TBL_IDX_W);
    localparam int TAW      = $clog2(TDEPTH);
    localparam int POS_W    = SLOT_W + tlpt_pkg::TBL_IDX_W;
    localparam logic [tlpt_pkg::TBL_IDX_W-1:0] IDX_LAST = '1;
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TABLE_SLOTS);

    // sequencer states
    localparam logic [2:0] S_CLR_DIR = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_DIR     = 3'd2;
    localparam logic [2:0] S_CLR_TBL = 3'd3;
    localparam logic [2:0] S_TRD     = 3'd4;
    localparam logic [2:0] S_RESP    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [tlpt_pkg::TBL_IDX_W-1:0] cnt_reg, cnt_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0] free_reg, free_next;

    // captured request
    logic [tlpt_pkg::OP_W-1:0]    op_reg;
    logic [tlpt_pkg::ADDR_W-1:0]  va_reg;
    logic [tlpt_pkg::ADDR_W-1:0]  pa_reg;
    logic [tlpt_pkg::FLAGS_W-1:0] flags_reg;

    // output register and the result waiting behind it
    logic                  out_valid_reg;
    tlpt_pkg::result_t     out_reg;
    tlpt_pkg::result_t     pend_reg;
    tlpt_pkg::result_t     fin_res;
    logic                  fin;
    logic                  out_free;

    // directory store: valid bit over slot number
    logic [DIR_W-1:0] dir_mem [0:tlpt_pkg::DIR_DEPTH-1];
    logic [DIR_W-1:0] dir_rd_reg;
    logic                           dir_we;
    logic [tlpt_pkg::DIR_IDX_W-1:0] dir_addr;
    logic [DIR_W-1:0]               dir_wdata;
    logic                           dir_valid;
    logic [SLOT_W-1:0]              dir_slot;

    // table store access
    logic                         tbl_we;
    logic [SLOT_W-1:0]            slot_sel;
    logic [tlpt_pkg::TBL_IDX_W-1:0] idx_sel;
    logic [POS_W-1:0]             tbl_pos;
    logic [TAW-1:0]               tbl_addr;
    logic [tlpt_pkg::ENTRY_W-1:0] tbl_wdata;
    logic [tlpt_pkg::ENTRY_W-1:0] tbl_rdata;

    logic                           accept;
    logic [tlpt_pkg::TBL_IDX_W-1:0] tidx;
    logic [tlpt_pkg::ENTRY_W-1:0]   new_entry;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign tidx      = va_reg[tlpt_pkg::OFFS_W +: tlpt_pkg::TBL_IDX_W];
    // frame over the flag bits
    assign new_entry = {pa_reg[tlpt_pkg::ADDR_W-1:tlpt_pkg::OFFS_W], flags_reg};
    assign dir_valid = dir_rd_reg[SLOT_W];
    assign dir_slot  = dir_rd_reg[SLOT_W-1:0];
    assign tbl_pos   = {slot_sel, idx_sel};
    assign tbl_addr  = tbl_pos[TAW-1:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        slot_next  = slot_reg;
        free_next  = free_reg;
        dir_we     = 1'b0;
        dir_addr   = va_reg[tlpt_pkg::ADDR_W-1 -: tlpt_pkg::DIR_IDX_W];
        dir_wdata  = '0;
        tbl_we     = 1'b0;
        slot_sel   = dir_slot;
        idx_sel    = tidx;
        tbl_wdata  = '0;
        fin        = 1'b0;
        fin_res.addr   = '0;
        fin_res.hit    = 1'b0;
        fin_res.status = tlpt_pkg::ST_DONE;

        case (state_reg)
            S_CLR_DIR:
            begin
                // mark every directory entry invalid
                dir_we   = 1'b1;
                dir_addr = cnt_reg;
                if (cnt_reg == IDX_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                dir_addr = s_axis_tdata[tlpt_pkg::ADDR_W-1 -: tlpt_pkg::DIR_IDX_W];
                if (accept)
                begin
                    state_next = S_DIR;
                end
            end
            S_DIR:
            begin
                case (op_reg)
                    tlpt_pkg::OP_MAP:
                    begin
                        if (!dir_valid)
                        begin
                            if (free_reg >= SLOTS_CNT)
                            begin
                                fin            = 1'b1;
                                fin_res.status = tlpt_pkg::ST_NOSLOT;
                            end
                            else
                            begin
                                // take the next slot and sweep its table
                                dir_we     = 1'b1;
                                dir_wdata  = {1'b1, free_reg[SLOT_W-1:0]};
                                slot_next  = free_reg[SLOT_W-1:0];
                                free_next  = free_reg + 1'b1;
                                cnt_next   = '0;
                                state_next = S_CLR_TBL;
                            end
                        end
                        else
                        begin
                            tbl_we    = 1'b1;
                            tbl_wdata = new_entry;
                            fin       = 1'b1;
                        end
                    end
                    tlpt_pkg::OP_UNMAP:
                    begin
                        fin = 1'b1;
                        if (!dir_valid)
                        begin
                            fin_res.status = tlpt_pkg::ST_NOTABLE;
                        end
                        else
                        begin
                            tbl_we = 1'b1;
                        end
                    end
                    tlpt_pkg::OP_XLATE:
                    begin
                        if (!dir_valid)
                        begin
                            fin            = 1'b1;
                            fin_res.status = tlpt_pkg::ST_NOTABLE;
                        end
                        else
                        begin
                            state_next = S_TRD;
                        end
                    end
                    default:
                    begin
                        // unused code: no change, all-zero result
                        fin = 1'b1;
                    end
                endcase
            end
            S_CLR_TBL:
            begin
                // zero the new table, dropping the mapped entry in on its way past
                tbl_we    = 1'b1;
                slot_sel  = slot_reg;
                idx_sel   = cnt_reg;
                tbl_wdata = (cnt_reg == tidx) ? new_entry : '0;
                if (cnt_reg == IDX_LAST)
                begin
                    cnt_next = '0;
                    fin      = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_TRD:
            begin
                fin = 1'b1;
                if (tbl_rdata[0])
                begin
                    // frame over page offset
                    fin_res.addr = {tbl_rdata[tlpt_pkg::ENTRY_W-1:tlpt_pkg::OFFS_W],
                                    va_reg[tlpt_pkg::OFFS_W-1:0]};
                    fin_res.hit  = 1'b1;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next = out_free ? S_IDLE : S_RESP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR_DIR;
            cnt_reg       <= '0;
            slot_reg      <= '0;
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            slot_reg  <= slot_next;
            free_reg  <= free_next;
            if ((fin || (state_reg == S_RESP)) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= s_axis_tuser;
            va_reg    <= s_axis_tdata[tlpt_pkg::ADDR_W-1:0];
            pa_reg    <= s_axis_tdata[2*tlpt_pkg::ADDR_W-1:tlpt_pkg::ADDR_W];
            flags_reg <= s_axis_tdata[2*tlpt_pkg::ADDR_W +: tlpt_pkg::FLAGS_W];
        end
        if (fin && out_free)
        begin
            out_reg <= fin_res;
        end
        else if ((state_reg == S_RESP) && out_free)
        begin
            out_reg <= pend_reg;
        end
        if (fin && !out_free)
        begin
            pend_reg <= fin_res;
        end
    end

    // directory memory
    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_mem[dir_addr] <= dir_wdata;
        end
        dir_rd_reg <= dir_mem[dir_addr];
    end

    tlpt_table_ram #(
        .DEPTH (TDEPTH),
        .AW    (TAW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .addr  (tbl_addr),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(tlpt_pkg::OUT_DATA_W - tlpt_pkg::ADDR_W - 1
                             - tlpt_pkg::STATUS_W){1'b0}},
                            out_reg.status, out_reg.hit, out_reg.addr};

`ifndef SYNTHESIS
    // the slot count never runs past the number of slots
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= SLOTS_CNT)
        else $error("slot count beyond table slots");

    // one request at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("request accepted while busy");

    // a refused map only once every slot is taken
    a_noslot_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_reg.status == tlpt_pkg::ST_NOSLOT)) |-> (free_reg == SLOTS_CNT))
        else $error("map refused with slots left");

    // a hit always comes with done status
    a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.hit) |-> (out_reg.status == tlpt_pkg::ST_DONE))
        else $error("hit with failing status");

    // a result beat never starts out of an idle sequencer
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) != S_IDLE))
        else $error("result beat without a request in flight");
`endif

endmodule
